@@ hdl/mrf_pkg.sv @@
// Shared types and constants for the message ring FIFO.
// Depends on nothing; every other file of the block imports it.
package mrf_pkg;

   localparam int SLOTS_DEFAULT         = 16;
   localparam int MESSAGE_BYTES_DEFAULT = 32;

   // Width of lengths, offsets, limits and byte counts (up to 127 bytes).
   localparam int LEN_W = 7;
   // Widest slot index carried through the job queue (up to 1024 slots).
   localparam int SLOT_IDX_MAX_W = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   // Read jobs that can be outstanding: the queue plus the one in the back end.
   localparam int RDP_W       = $clog2(QUEUE_DEPTH + 2);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_REFUSED = 2'd1,
      ST_BYTE    = 2'd2,
      ST_NOTHING = 2'd3
   } status_type;

   typedef enum logic {
      JOB_RESULT = 1'b0,
      JOB_READ   = 1'b1
   } job_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_LEN  = 2'd1,
      BK_RUN  = 2'd2
   } back_state_type;

   typedef struct packed {
      job_kind_type              kind;
      status_type                status;
      logic [LEN_W-1:0]          count;
      logic [SLOT_IDX_MAX_W-1:0] slot;
      logic [LEN_W-1:0]          limit;
   } job_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       data;
      logic [LEN_W-1:0] count;
      logic             last;
   } rsp_type;

endpackage

@@ hdl/mrf_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on mrf_pkg for the field widths.
interface mrf_req_if
   import mrf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [7:0]       data_byte;
   logic             has_byte;
   logic             end_of_message;
   logic [LEN_W-1:0] read_limit;

   modport source (output valid, command, data_byte, has_byte, end_of_message,
                   read_limit, input ready);
   modport sink   (input valid, command, data_byte, has_byte, end_of_message,
                   read_limit, output ready);
endinterface

interface mrf_rsp_if
   import mrf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [7:0]       data_byte_res;
   logic [LEN_W-1:0] byte_count;
   logic             last;

   modport source (output valid, status, data_byte_res, byte_count, last,
                   input ready);
   modport sink   (input valid, status, data_byte_res, byte_count, last,
                   output ready);
endinterface

@@ hdl/mrf_front.sv @@
// Front end: accepts request beats, tracks ring pointers and the open message,
// writes message bytes and lengths, and queues result and read jobs.
// Depends on mrf_pkg and mrf_if.
module mrf_front
   import mrf_pkg::*;
#(
   parameter int SLOTS         = SLOTS_DEFAULT,
   parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int ADDR_W = $clog2(SLOTS * MESSAGE_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   mrf_req_if.sink           req_if,
   output logic              job_valid,
   input  logic              job_ready,
   output job_type           job,
   input  logic              read_done,
   output logic              store_we,
   output logic [ADDR_W-1:0] store_waddr,
   output logic [7:0]        store_wdata,
   output logic              len_we,
   output logic [SLOT_W-1:0] len_waddr,
   output logic [LEN_W-1:0]  len_wdata
);
   localparam int OCC_W = $clog2(SLOTS + 1);

   logic [SLOT_W-1:0] rslot_ff, rslot_in, wslot_ff, wslot_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic              in_msg_ff, in_msg_in;
   logic              refused_ff, refused_in;
   logic [RDP_W-1:0]  rdp_ff, rdp_in;

   logic             accept, is_write, start, refused, take, read_ok;
   logic [LEN_W-1:0] off, off_new;

   // Writes wait while any read job is in flight, so the back end never
   // reads a slot that is being refilled.
   assign req_if.ready = job_ready && (req_if.command == CMD_READ || rdp_ff == '0);
   assign accept   = req_if.valid && req_if.ready;
   assign is_write = req_if.command == CMD_WRITE;

   assign start   = !in_msg_ff;
   assign refused = start ? (occ_ff >= OCC_W'(SLOTS)) : refused_ff;
   assign off     = start ? '0 : off_ff;
   assign take    = req_if.has_byte && !refused && (off < LEN_W'(MESSAGE_BYTES));
   assign off_new = take ? off + LEN_W'(1) : off;
   assign read_ok = (occ_ff != '0) && (req_if.read_limit != '0);

   assign store_we    = accept && is_write && take;
   assign store_waddr = ADDR_W'(wslot_ff) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(off);
   assign store_wdata = req_if.data_byte;
   assign len_we      = accept && is_write && req_if.end_of_message && !refused;
   assign len_waddr   = wslot_ff;
   assign len_wdata   = off_new;

   always_comb begin
      job        = '0;
      job_valid  = 1'b0;
      rslot_in   = rslot_ff;
      wslot_in   = wslot_ff;
      occ_in     = occ_ff;
      off_in     = off_ff;
      in_msg_in  = in_msg_ff;
      refused_in = refused_ff;
      if (accept) begin
         if (is_write) begin
            in_msg_in  = 1'b1;
            refused_in = refused;
            off_in     = off_new;
            if (req_if.end_of_message) begin
               job_valid  = 1'b1;
               job.kind   = JOB_RESULT;
               in_msg_in  = 1'b0;
               refused_in = 1'b0;
               off_in     = '0;
               if (refused) begin
                  job.status = ST_REFUSED;
               end else begin
                  job.status = ST_STORED;
                  job.count  = off_new;
                  wslot_in   = (wslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : wslot_ff + SLOT_W'(1);
                  occ_in     = occ_ff + OCC_W'(1);
               end
            end
         end else begin
            job_valid = 1'b1;
            if (read_ok) begin
               job.kind  = JOB_READ;
               job.slot  = SLOT_IDX_MAX_W'(rslot_ff);
               job.limit = req_if.read_limit;
               rslot_in  = (rslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : rslot_ff + SLOT_W'(1);
               occ_in    = occ_ff - OCC_W'(1);
            end else begin
               job.kind   = JOB_RESULT;
               job.status = ST_NOTHING;
            end
         end
      end
   end

   always_comb begin
      rdp_in = rdp_ff;
      if (accept && !is_write && read_ok) begin
         rdp_in = rdp_in + RDP_W'(1);
      end
      if (read_done) begin
         rdp_in = rdp_in - RDP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rslot_ff   <= '0;
         wslot_ff   <= '0;
         occ_ff     <= '0;
         off_ff     <= '0;
         in_msg_ff  <= 1'b0;
         refused_ff <= 1'b0;
         rdp_ff     <= '0;
      end else begin
         rslot_ff   <= rslot_in;
         wslot_ff   <= wslot_in;
         occ_ff     <= occ_in;
         off_ff     <= off_in;
         in_msg_ff  <= in_msg_in;
         refused_ff <= refused_in;
         rdp_ff     <= rdp_in;
      end
   end

endmodule

@@ hdl/mrf_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on mrf_pkg for the job type and depth.
module mrf_queue
   import mrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);
   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;

   assign push_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = slot_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wptr_in = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/mrf_back.sv @@
// Back end: holds the message and length memories, carries out queued jobs
// and drives response beats through a two-entry output buffer.
// Depends on mrf_pkg and mrf_if.
module mrf_back
   import mrf_pkg::*;
#(
   parameter int SLOTS         = SLOTS_DEFAULT,
   parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int ADDR_W = $clog2(SLOTS * MESSAGE_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  job_type           job,
   output logic              read_done,
   input  logic              store_we,
   input  logic [ADDR_W-1:0] store_waddr,
   input  logic [7:0]        store_wdata,
   input  logic              len_we,
   input  logic [SLOT_W-1:0] len_waddr,
   input  logic [LEN_W-1:0]  len_wdata,
   mrf_rsp_if.source         rsp_if
);
   logic [7:0]       store_mem [SLOTS * MESSAGE_BYTES];
   logic [LEN_W-1:0] len_mem   [SLOTS];
   logic [7:0]       st_rdata_ff;
   logic [LEN_W-1:0] len_rdata_ff;

   back_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic [LEN_W-1:0]  n_ff, n_in, idx_ff, idx_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              rd_pend_ff, rd_pend_in, rd_last_ff, rd_last_in;

   rsp_type    out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0] ocnt_ff, ocnt_in;

   logic             pop, can_direct, can_issue;
   logic [1:0]       cnt_after_pop;
   logic [LEN_W-1:0] lim_c, len_c, n_calc;
   logic             direct_push, push;
   rsp_type          direct_data, push_data;
   logic             len_re, st_re;
   logic [ADDR_W-1:0] st_raddr;

   // Both limit and stored length are clamped to the slot size.
   assign lim_c  = (limit_ff > LEN_W'(MESSAGE_BYTES)) ? LEN_W'(MESSAGE_BYTES) : limit_ff;
   assign len_c  = (len_rdata_ff > LEN_W'(MESSAGE_BYTES)) ? LEN_W'(MESSAGE_BYTES)
                                                          : len_rdata_ff;
   assign n_calc = (lim_c < len_c) ? lim_c : len_c;

   assign pop           = (ocnt_ff != 2'd0) && rsp_if.ready;
   assign cnt_after_pop = ocnt_ff - 2'(pop);
   // A store read lands in the following cycle, so it needs room after that landing.
   assign can_direct    = !rd_pend_ff && (cnt_after_pop < 2'd2);
   assign can_issue     = rd_pend_ff ? (cnt_after_pop == 2'd0) : (cnt_after_pop < 2'd2);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid && job.kind == JOB_READ) begin
               state_in = BK_LEN;
            end
         end
         BK_LEN: begin
            if (n_calc != '0) begin
               state_in = BK_RUN;
            end else if (can_direct) begin
               state_in = BK_IDLE;
            end
         end
         BK_RUN: begin
            if (can_issue && idx_ff + LEN_W'(1) == n_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      job_ready   = 1'b0;
      read_done   = 1'b0;
      direct_push = 1'b0;
      direct_data = '0;
      len_re      = 1'b0;
      st_re       = 1'b0;
      st_raddr    = base_ff + ADDR_W'(idx_ff);
      slot_in     = slot_ff;
      limit_in    = limit_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      rd_pend_in  = 1'b0;
      rd_last_in  = rd_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               if (job.kind == JOB_READ) begin
                  job_ready = 1'b1;
                  len_re    = 1'b1;
                  slot_in   = job.slot[SLOT_W-1:0];
                  limit_in  = job.limit;
               end else if (can_direct) begin
                  job_ready          = 1'b1;
                  direct_push        = 1'b1;
                  direct_data.status = job.status;
                  direct_data.count  = job.count;
                  direct_data.last   = 1'b1;
               end
            end
         end
         BK_LEN: begin
            base_in = ADDR_W'(slot_ff) * ADDR_W'(MESSAGE_BYTES);
            n_in    = n_calc;
            idx_in  = '0;
            if (n_calc == '0 && can_direct) begin
               // A zero-length message is consumed and answers with nothing.
               read_done          = 1'b1;
               direct_push        = 1'b1;
               direct_data.status = ST_NOTHING;
               direct_data.last   = 1'b1;
            end
         end
         BK_RUN: begin
            if (can_issue) begin
               st_re      = 1'b1;
               rd_pend_in = 1'b1;
               rd_last_in = idx_ff + LEN_W'(1) == n_ff;
               idx_in     = idx_ff + LEN_W'(1);
               read_done  = idx_ff + LEN_W'(1) == n_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      push_data        = direct_data;
      push             = direct_push;
      if (rd_pend_ff) begin
         push             = 1'b1;
         push_data.status = ST_BYTE;
         push_data.data   = st_rdata_ff;
         push_data.count  = n_ff;
         push_data.last   = rd_last_ff;
      end
   end

   always_comb begin
      out0_in = out0_ff;
      out1_in = out1_ff;
      if (pop) begin
         out0_in = out1_ff;
      end
      if (push) begin
         if (cnt_after_pop == 2'd0) begin
            out0_in = push_data;
         end else begin
            out1_in = push_data;
         end
      end
      ocnt_in = cnt_after_pop + 2'(push);
   end

   assign rsp_if.valid         = ocnt_ff != 2'd0;
   assign rsp_if.status        = out0_ff.status;
   assign rsp_if.data_byte_res = out0_ff.data;
   assign rsp_if.byte_count    = out0_ff.count;
   assign rsp_if.last          = out0_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         rd_pend_ff <= 1'b0;
         ocnt_ff    <= 2'd0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      limit_ff   <= limit_in;
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      base_ff    <= base_in;
      rd_last_ff <= rd_last_in;
      out0_ff    <= out0_in;
      out1_ff    <= out1_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (st_re) begin
         st_rdata_ff <= store_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (len_re) begin
         len_rdata_ff <= len_mem[slot_in];
      end
   end

endmodule

@@ hdl/message_ring_fifo.sv @@
// Message ring FIFO: a message of write beats closes with one acknowledgement;
// a read beat is queued as a job, then the back end pops it, looks up the
// length and streams the message one byte per cycle, unless the response side
// stalls, through the single read port of the byte store.
// Write beats wait while read jobs are queued or running, and a full job
// queue of four entries holds off every beat. No clearing pass follows reset.
// Depends on mrf_pkg, mrf_if, mrf_front, mrf_queue and mrf_back.
module message_ring_fifo
   import mrf_pkg::*;
#(
   parameter int SLOTS         = SLOTS_DEFAULT,
   parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_if,
   mrf_rsp_if.source rsp_if
);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ADDR_W = $clog2(SLOTS * MESSAGE_BYTES);

   logic              fq_valid, fq_ready, qb_valid, qb_ready, read_done;
   job_type           fq_job, qb_job;
   logic              store_we, len_we;
   logic [ADDR_W-1:0] store_waddr;
   logic [7:0]        store_wdata;
   logic [SLOT_W-1:0] len_waddr;
   logic [LEN_W-1:0]  len_wdata;

   mrf_front #(.SLOTS(SLOTS), .MESSAGE_BYTES(MESSAGE_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job         (fq_job),
      .read_done   (read_done),
      .store_we    (store_we),
      .store_waddr (store_waddr),
      .store_wdata (store_wdata),
      .len_we      (len_we),
      .len_waddr   (len_waddr),
      .len_wdata   (len_wdata)
   );

   mrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   mrf_back #(.SLOTS(SLOTS), .MESSAGE_BYTES(MESSAGE_BYTES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job         (qb_job),
      .read_done   (read_done),
      .store_we    (store_we),
      .store_waddr (store_waddr),
      .store_wdata (store_wdata),
      .len_we      (len_we),
      .len_waddr   (len_waddr),
      .len_wdata   (len_wdata),
      .rsp_if      (rsp_if)
   );

endmodule

@@ hdl/mrf_checker.sv @@
// Port-level checks on the response channel of the message ring FIFO.
// Depends on mrf_pkg; bound to message_ring_fifo below.
module mrf_checker
   import mrf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_status,
   input logic [7:0]       rsp_data_byte_res,
   input logic [LEN_W-1:0] rsp_byte_count,
   input logic             rsp_last
);

   // A stalled response beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_byte_count) && $stable(rsp_data_byte_res) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // Acknowledgements, refusals and nothing-results always close their run with no data.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BYTE |-> rsp_last && rsp_data_byte_res == '0)
      else $error("single-beat result without last or with data");

   // Refusals and nothing-results carry no count.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_REFUSED || rsp_status == ST_NOTHING)
         |-> rsp_byte_count == '0)
      else $error("refusal or nothing-result with nonzero count");

   // Within a byte run the count stays the same until the last byte is taken.
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == ST_BYTE && !rsp_last ##1 rsp_valid
         |-> rsp_status == ST_BYTE && rsp_byte_count == $past(rsp_byte_count)
            && rsp_byte_count != '0)
      else $error("byte run broken or count changed");

endmodule

bind message_ring_fifo mrf_checker u_mrf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_data_byte_res (rsp_if.data_byte_res),
   .rsp_byte_count    (rsp_if.byte_count),
   .rsp_last          (rsp_if.last)
);

@@ tb/message_ring_fifo_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for message_ring_fifo: a directed plan, then random message traffic.
// Results are checked beat by beat against a predictor of the slot ring.
// Depends on mrf_pkg, mrf_if and the message_ring_fifo RTL.
module message_ring_fifo_tb;
   import mrf_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int MSG_BYTES    = MESSAGE_BYTES_DEFAULT;
   localparam int RANDOM_BEATS = 400;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic             command;
      logic [7:0]       data;
      logic             has_byte;
      logic             eom;
      logic [LEN_W-1:0] limit;
   } beat_type;

   typedef struct {
      beat_type   beat;
      int         reps;
      bit         typed;
      status_type st;
      int         cnt;
   } plan_row_type;

   logic clock;
   logic reset;

   mrf_req_if req_ch ();
   mrf_rsp_if rsp_ch ();

   message_ring_fifo #(.SLOTS(SLOTS), .MESSAGE_BYTES(MSG_BYTES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predicted state of the slot ring.
   logic [7:0] ring_bytes [SLOTS*MSG_BYTES];
   int         ring_len [SLOTS];
   int         rd_slot = 0;
   int         wr_slot = 0;
   int         held = 0;
   int         wr_off = 0;
   bit         open_msg = 1'b0;
   bit         refused_msg = 1'b0;

   rsp_type      awaited [$];
   plan_row_type plan [$];

   int mismatches   = 0;
   int beats_sent   = 0;
   int stored_msgs  = 0;
   int refused_msgs = 0;
   int bytes_back   = 0;
   int empty_reads  = 0;
   bit quiet        = 1'b0;
   bit hold_armed   = 1'b0;
   bit hold_done    = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic rsp_type make_rsp(status_type st, logic [7:0] d, int cnt, logic lst);
      rsp_type r;
      r.status = st;
      r.data   = d;
      r.count  = cnt[LEN_W-1:0];
      r.last   = lst;
      return r;
   endfunction

   function automatic beat_type write_beat(logic [7:0] d, logic has, logic eom);
      beat_type b;
      b.command  = CMD_WRITE;
      b.data     = d;
      b.has_byte = has;
      b.eom      = eom;
      b.limit    = '0;
      return b;
   endfunction

   function automatic beat_type read_beat(int lim);
      beat_type b;
      b.command  = CMD_READ;
      b.data     = '0;
      b.has_byte = 1'b0;
      b.eom      = 1'b0;
      b.limit    = lim[LEN_W-1:0];
      return b;
   endfunction

   function automatic plan_row_type make_row(beat_type b, int reps, bit typed,
                                             status_type st, int cnt);
      plan_row_type r;
      r.beat  = b;
      r.reps  = reps;
      r.typed = typed;
      r.st    = st;
      r.cnt   = cnt;
      return r;
   endfunction

   // Mostly short messages, some up to a full slot, a few oversized.
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 70) return $urandom_range(1, 6);
      if (r < 92) return $urandom_range(7, MSG_BYTES);
      return $urandom_range(MSG_BYTES + 1, MSG_BYTES + 8);
   endfunction

   function automatic int pick_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 0;
      if (r < 16) return 64;
      if (r < 24) return $urandom_range(MSG_BYTES + 1, 63);
      return $urandom_range(1, MSG_BYTES);
   endfunction

   // Advances the ring prediction by one accepted beat and queues its results.
   // A typed row queues its hand-written result instead of the predicted one.
   task automatic ring_step(input beat_type b, input bit typed, input rsp_type typed_rsp);
      rsp_type made [$];
      int      len;
      int      n;
      if (b.command == CMD_WRITE) begin
         if (!open_msg) begin
            open_msg    = 1'b1;
            wr_off      = 0;
            refused_msg = (held >= SLOTS);
         end
         if (b.has_byte && !refused_msg && wr_off < MSG_BYTES) begin
            ring_bytes[wr_slot*MSG_BYTES + wr_off] = b.data;
            wr_off++;
         end
         if (b.eom) begin
            if (refused_msg) begin
               made.push_back(make_rsp(ST_REFUSED, 8'h00, 0, 1'b1));
            end else begin
               ring_len[wr_slot] = wr_off;
               made.push_back(make_rsp(ST_STORED, 8'h00, wr_off, 1'b1));
               wr_slot = (wr_slot + 1) % SLOTS;
               held++;
            end
            open_msg    = 1'b0;
            refused_msg = 1'b0;
            wr_off      = 0;
         end
      end else if (held == 0 || b.limit == 0) begin
         made.push_back(make_rsp(ST_NOTHING, 8'h00, 0, 1'b1));
      end else begin
         len = ring_len[rd_slot];
         n   = (int'(b.limit) < len) ? int'(b.limit) : len;
         for (int i = 0; i < n; i++) begin
            made.push_back(make_rsp(ST_BYTE, ring_bytes[rd_slot*MSG_BYTES + i], n, i == n - 1));
         end
         rd_slot = (rd_slot + 1) % SLOTS;
         held--;
         // A zero-length message is consumed but answers with nothing.
         if (n == 0) made.push_back(make_rsp(ST_NOTHING, 8'h00, 0, 1'b1));
      end
      if (typed) begin
         awaited.push_back(typed_rsp);
      end else begin
         foreach (made[i]) awaited.push_back(made[i]);
      end
   endtask

   task automatic drive_beat(input beat_type b, input bit typed, input rsp_type typed_rsp);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.command        <= b.command;
      req_ch.data_byte      <= b.data;
      req_ch.has_byte       <= b.has_byte;
      req_ch.end_of_message <= b.eom;
      req_ch.read_limit     <= b.limit;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      beats_sent++;
      ring_step(b, typed, typed_rsp);
   endtask

   // A message with random content, now and then padded with empty beats or
   // interrupted by a read; some end on a beat that carries no byte.
   task automatic send_message(input int n_bytes);
      bit bare_end;
      bare_end = (n_bytes == 0) || ($urandom_range(0, 7) == 0);
      for (int k = 0; k < n_bytes; k++) begin
         if ($urandom_range(0, 11) == 0)
            drive_beat(write_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0), 1'b0, '0);
         if ($urandom_range(0, 19) == 0)
            drive_beat(read_beat(pick_limit()), 1'b0, '0);
         drive_beat(write_beat(8'($urandom_range(0, 255)), 1'b1, !bare_end && k == n_bytes - 1),
                    1'b0, '0);
      end
      if (bare_end) drive_beat(write_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1), 1'b0, '0);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         case (rsp_ch.status)
            ST_STORED:  stored_msgs++;
            ST_REFUSED: refused_msgs++;
            ST_BYTE:    bytes_back++;
            default:    empty_reads++;
         endcase
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected: status %0d byte %h count %0d last %0b",
                     $time, rsp_ch.status, rsp_ch.data_byte_res, rsp_ch.byte_count,
                     rsp_ch.last);
         end else begin
            want = awaited.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.data_byte_res !== want.data ||
                rsp_ch.byte_count !== want.count || rsp_ch.last !== want.last) begin
               mismatches++;
               $display("%0t: expected status %0d byte %h count %0d last %0b,",
                        $time, want.status, want.data, want.count, want.last,
                        " got status %0d byte %h count %0d last %0b",
                        rsp_ch.status, rsp_ch.data_byte_res, rsp_ch.byte_count,
                        rsp_ch.last);
            end
         end
      end
   end

   // Result side: random stall bursts, one long hold-off that backs the
   // block up to its input, and no stalls at all near the end.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(0, 4) == 0 ? 30 : $urandom_range(1, 10)) @(posedge clock);
      end
   end

   initial begin
      int plan_beats;
      int next_mode;
      int write_share;
      int waited;
      beat_type b;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.command        <= CMD_WRITE;
      req_ch.data_byte      <= 8'h00;
      req_ch.has_byte       <= 1'b0;
      req_ch.end_of_message <= 1'b0;
      req_ch.read_limit     <= '0;

      // Typed rows carry results that follow directly from the ring's state.
      plan.push_back(make_row(read_beat(5), 1, 1'b1, ST_NOTHING, 0));
      plan.push_back(make_row(write_beat(8'h00, 1'b0, 1'b1), 1, 1'b1, ST_STORED, 0));
      plan.push_back(make_row(read_beat(64), 1, 1'b1, ST_NOTHING, 0));
      plan.push_back(make_row(write_beat(8'h00, 1'b1, 1'b0), 1, 1'b0, ST_STORED, 0));
      plan.push_back(make_row(write_beat(8'h3C, 1'b0, 1'b0), 1, 1'b0, ST_STORED, 0));
      plan.push_back(make_row(write_beat(8'hFF, 1'b1, 1'b1), 1, 1'b1, ST_STORED, 2));
      plan.push_back(make_row(read_beat(0), 1, 1'b1, ST_NOTHING, 0));
      plan.push_back(make_row(read_beat(64), 1, 1'b0, ST_NOTHING, 0));
      plan.push_back(make_row(write_beat(8'h80, 1'b1, 1'b1), SLOTS, 1'b1, ST_STORED, 1));
      plan.push_back(make_row(write_beat(8'h5A, 1'b1, 1'b1), 1, 1'b1, ST_REFUSED, 0));
      plan.push_back(make_row(read_beat(1), 1, 1'b0, ST_NOTHING, 0));
      plan.push_back(make_row(write_beat(8'h11, 1'b1, 1'b0), 1, 1'b0, ST_NOTHING, 0));
      plan.push_back(make_row(read_beat(64), 1, 1'b0, ST_NOTHING, 0));
      plan.push_back(make_row(write_beat(8'h22, 1'b1, 1'b1), 1, 1'b1, ST_STORED, 2));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            b = plan[r].beat;
            if (b.command == CMD_WRITE) b.data = b.data + 8'(k);
            drive_beat(b, plan[r].typed, make_rsp(plan[r].st, 8'h00, plan[r].cnt, 1'b1));
         end
      end
      plan_beats = beats_sent;

      // Windows of fifty beats lean toward filling or toward draining the ring.
      next_mode   = plan_beats;
      write_share = 5;
      while (beats_sent < plan_beats + RANDOM_BEATS) begin
         if (beats_sent >= next_mode) begin
            write_share = $urandom_range(2, 8);
            next_mode   = next_mode + 50;
         end
         if (beats_sent >= plan_beats + 120) hold_armed = 1'b1;
         if (beats_sent >= plan_beats + RANDOM_BEATS - 60) quiet = 1'b1;
         if ($urandom_range(1, 10) <= write_share)
            send_message(pick_length());
         else
            drive_beat(read_beat(pick_limit()), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (awaited.size() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (awaited.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited.size());
         mismatches = mismatches + awaited.size();
      end

      $display("Sent %0d beats (%0d in the directed plan); saw %0d messages stored, %0d refused,",
               beats_sent, plan_beats, stored_msgs, refused_msgs);
      $display("%0d bytes read back and %0d empty read answers; %0d mismatches.",
               bytes_back, empty_reads, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
